// ===== rtl/core/blm_pkg.sv =====
package blm_pkg;

  // fixed field widths
  localparam int ADC_W   = 12;
  localparam int LEVEL_W = 16;
  localparam int COLOR_W = 2;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 2;

  // default build
  localparam int DEF_WINDOW_DEPTH = 16;
  localparam int DEF_ADC_BITS     = 12;

  // register reset values
  localparam logic [CFG_W-1:0] RST_POLL_INTERVAL = 16'd1000;
  localparam logic [CFG_W-1:0] RST_HIGH_LIMIT    = 16'd14800;
  localparam logic [CFG_W-1:0] RST_MEDIUM_LIMIT  = 16'd14000;
  localparam logic [CFG_W-1:0] RST_LOW_LIMIT     = 16'd13200;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLL_INTERVAL = 2'd0,
    REG_HIGH_LIMIT    = 2'd1,
    REG_MEDIUM_LIMIT  = 2'd2,
    REG_LOW_LIMIT     = 2'd3
  } cfg_reg_t;

  // level colours
  typedef enum logic [COLOR_W-1:0] {
    COLOR_GREEN  = 2'd0,
    COLOR_YELLOW = 2'd1,
    COLOR_ORANGE = 2'd2,
    COLOR_RED    = 2'd3
  } color_t;

  // controller to datapath
  typedef struct packed {
    logic tick;
    logic update;
    logic div_init;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic poll;
    logic div_done;
    logic out_free;
  } ctrl_stat_t;

endpackage

// ===== rtl/core/blm_if.sv =====
// tick channel
interface blm_tick_if;
  logic                       valid;
  logic                       ready;
  logic [blm_pkg::ADC_W-1:0]  adc_reading;
  logic                       led_allowed;

  modport source (output valid, output adc_reading, output led_allowed, input ready);
  modport sink   (input valid, input adc_reading, input led_allowed, output ready);
endinterface

// level result channel
interface blm_level_if;
  logic                         valid;
  logic                         ready;
  logic [blm_pkg::LEVEL_W-1:0]  average_level;
  logic [blm_pkg::COLOR_W-1:0]  level_color;
  logic                         color_update;

  modport source (output valid, output average_level, output level_color,
                  output color_update, input ready);
  modport sink   (input valid, input average_level, input level_color,
                  input color_update, output ready);
endinterface

// ===== rtl/core/blm_ctrl.sv =====
module blm_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   tick_valid,
  output logic                   tick_ready,
  input  blm_pkg::ctrl_stat_t    stat,
  output blm_pkg::ctrl_cmd_t     cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_UPDATE,
    S_DIV_INIT,
    S_DIVIDE,
    S_FINISH
  } state_t;

  state_t state;
  state_t state_next;

  // tick acceptance and the sequencing of one poll
  always_comb begin
    state_next   = state;
    cmd          = '0;
    tick_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        tick_ready = 1'b1;
        if (tick_valid) begin
          cmd.tick = 1'b1;
          if (stat.poll) state_next = S_UPDATE;
        end
      end
      S_UPDATE: begin
        cmd.update = 1'b1;
        state_next = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = S_DIVIDE;
      end
      S_DIVIDE: begin
        if (stat.div_done) begin
          state_next = S_FINISH;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/core/blm_dp.sv =====
module blm_dp #(
  parameter int WINDOW_DEPTH = blm_pkg::DEF_WINDOW_DEPTH,
  parameter int ADC_BITS     = blm_pkg::DEF_ADC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  // tick word
  input  logic [blm_pkg::ADC_W-1:0]     adc_reading,
  input  logic                          led_allowed,
  // configuration
  input  logic                          cfg_write,
  input  logic [blm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [blm_pkg::CFG_W-1:0]     cfg_data,
  // control
  input  blm_pkg::ctrl_cmd_t            cmd,
  output blm_pkg::ctrl_stat_t           stat,
  // result word
  output logic                          level_valid,
  input  logic                          level_ready,
  output logic [blm_pkg::LEVEL_W-1:0]   average_level,
  output logic [blm_pkg::COLOR_W-1:0]   level_color,
  output logic                          color_update
);

  localparam int SLOT_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CNT_W   = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W   = blm_pkg::LEVEL_W + $clog2(WINDOW_DEPTH);
  localparam int DCNT_W  = $clog2(SUM_W + 1);
  localparam int ADC_USE = (ADC_BITS < blm_pkg::ADC_W) ? ADC_BITS : blm_pkg::ADC_W;
  localparam int SCL_W   = blm_pkg::ADC_W + 4;
  localparam logic [blm_pkg::ADC_W-1:0] ADC_MASK = blm_pkg::ADC_W'((1 << ADC_USE) - 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW_DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(WINDOW_DEPTH);

  // configuration registers
  logic [blm_pkg::CFG_W-1:0] poll_interval_ms;
  logic [blm_pkg::CFG_W-1:0] high_limit;
  logic [blm_pkg::CFG_W-1:0] medium_limit;
  logic [blm_pkg::CFG_W-1:0] low_limit;

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_interval_ms <= blm_pkg::RST_POLL_INTERVAL;
      high_limit       <= blm_pkg::RST_HIGH_LIMIT;
      medium_limit     <= blm_pkg::RST_MEDIUM_LIMIT;
      low_limit        <= blm_pkg::RST_LOW_LIMIT;
    end else if (cfg_write) begin
      unique case (blm_pkg::cfg_reg_t'(cfg_index))
        blm_pkg::REG_POLL_INTERVAL: poll_interval_ms <= cfg_data;
        blm_pkg::REG_HIGH_LIMIT:    high_limit       <= cfg_data;
        blm_pkg::REG_MEDIUM_LIMIT:  medium_limit     <= cfg_data;
        blm_pkg::REG_LOW_LIMIT:     low_limit        <= cfg_data;
        default: ;
      endcase
    end
  end

  // poll timer, saturating
  logic [blm_pkg::CFG_W-1:0] elapsed_ms;
  logic [blm_pkg::CFG_W-1:0] elapsed_inc;

  assign elapsed_inc = (elapsed_ms == '1) ? elapsed_ms : elapsed_ms + 1'b1;
  assign stat.poll   = (elapsed_inc >= poll_interval_ms);

  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_ms <= '0;
    end else if (cmd.tick) begin
      elapsed_ms <= stat.poll ? '0 : elapsed_inc;
    end
  end

  // scale by nine into quarter millivolts, saturate to 16 bits
  logic [blm_pkg::ADC_W-1:0]   adc_used;
  logic [SCL_W-1:0]            scaled;
  logic [blm_pkg::LEVEL_W-1:0] scaled_sat;

  assign adc_used   = adc_reading & ADC_MASK;
  assign scaled     = (SCL_W'(adc_used) << 3) + SCL_W'(adc_used);
  assign scaled_sat = (scaled > SCL_W'({blm_pkg::LEVEL_W{1'b1}})) ?
                      '1 : scaled[blm_pkg::LEVEL_W-1:0];

  // captured tick word
  logic [blm_pkg::LEVEL_W-1:0] sample;
  logic                        led_hold;

  always_ff @(posedge clk) begin
    if (cmd.tick) begin
      sample   <= scaled_sat;
      led_hold <= led_allowed;
    end
  end

  // sample ring, read on the tick, written on the update
  logic [blm_pkg::LEVEL_W-1:0] ring [WINDOW_DEPTH];
  logic [blm_pkg::LEVEL_W-1:0] ring_q;
  logic [SLOT_W-1:0]           write_slot;
  logic [CNT_W-1:0]            samples_held;

  always_ff @(posedge clk) begin
    if (cmd.tick) ring_q <= ring[write_slot];
    if (cmd.update) ring[write_slot] <= sample;
  end

  // running sum; a slot never written counts as zero until the window is full
  logic [SUM_W-1:0]            window_sum;
  logic [blm_pkg::LEVEL_W-1:0] old_sample;

  assign old_sample = (samples_held == FULL_CNT) ? ring_q : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_sum   <= '0;
      write_slot   <= '0;
      samples_held <= '0;
    end else if (cmd.update) begin
      window_sum   <= window_sum - SUM_W'(old_sample) + SUM_W'(sample);
      write_slot   <= (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
      if (samples_held != FULL_CNT) samples_held <= samples_held + 1'b1;
    end
  end

  // restoring divider, one quotient bit a cycle
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [DCNT_W-1:0] div_cnt;
  logic [CNT_W:0]    rem_sh;
  logic              rem_ge;

  assign rem_sh        = {rem, quo[SUM_W-1]};
  assign rem_ge        = (rem_sh >= {1'b0, samples_held});
  assign stat.div_done = (div_cnt == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.div_init) begin
      div_cnt <= DCNT_W'(SUM_W);
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo <= window_sum;
      rem <= '0;
    end else if (cmd.div_step) begin
      quo <= {quo[SUM_W-2:0], rem_ge};
      rem <= rem_ge ? CNT_W'(rem_sh - {1'b0, samples_held}) : rem_sh[CNT_W-1:0];
    end
  end

  // exact average against a limit: sum <= limit * n
  logic at_high;
  logic at_medium;
  logic at_low;
  logic rem_zero;
  blm_pkg::color_t color;

  assign rem_zero  = (rem == '0);
  assign at_high   = (quo < SUM_W'(high_limit)) ||
                     ((quo == SUM_W'(high_limit)) && rem_zero);
  assign at_medium = (quo < SUM_W'(medium_limit)) ||
                     ((quo == SUM_W'(medium_limit)) && rem_zero);
  assign at_low    = (quo < SUM_W'(low_limit)) ||
                     ((quo == SUM_W'(low_limit)) && rem_zero);

  always_comb begin
    priority if (at_high && !at_medium) begin
      color = blm_pkg::COLOR_YELLOW;
    end else if (at_medium && !at_low) begin
      color = blm_pkg::COLOR_ORANGE;
    end else if (at_low) begin
      color = blm_pkg::COLOR_RED;
    end else begin
      color = blm_pkg::COLOR_GREEN;
    end
  end

  // output register
  assign stat.out_free = !level_valid || level_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_valid <= 1'b0;
    end else if (cmd.out_load) begin
      level_valid <= 1'b1;
    end else if (level_ready) begin
      level_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      average_level <= quo[blm_pkg::LEVEL_W-1:0];
      level_color   <= color;
      color_update  <= led_hold;
    end
  end

endmodule

// ===== rtl/core/battery_level_monitor.sv =====
// Battery level monitor. Each word on ticks is one millisecond tick with the converter
// reading and the LED permission flag. Every poll_interval_ms ticks (the first at tick
// poll_interval_ms after reset) the reading is scaled by nine into quarter millivolts and
// entered into a moving average over the last WINDOW_DEPTH samples, dividing by the
// samples actually held until the window fills. One word then leaves on levels: the
// truncated average, a colour from the exact average against the high, medium and low
// limits (yellow, orange, red tested in that order, else green) and color_update equal
// to led_allowed. A tick that does not poll yields no word, and the block stays ready
// for the next tick. A poll tick holds the input through the update, the divider setup,
// the serial divide, which retires one quotient bit per cycle, and the output load.
// A finished word waits in an output register, so ticks that do not poll keep flowing
// while it is held; the next poll tick stays busy in its last cycle until that register
// is free. Registers are written on cfg_write with cfg_index 0 poll interval, 1 high
// limit, 2 medium limit, 3 low limit, and should be written while the block is idle.
module battery_level_monitor #(
  parameter int WINDOW_DEPTH = blm_pkg::DEF_WINDOW_DEPTH,
  parameter int ADC_BITS     = blm_pkg::DEF_ADC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  blm_tick_if.sink                      ticks,
  blm_level_if.source                   levels,
  input  logic                          cfg_write,
  input  logic [blm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [blm_pkg::CFG_W-1:0]     cfg_data
);

  blm_pkg::ctrl_cmd_t  cmd;
  blm_pkg::ctrl_stat_t stat;

  // sequencer
  blm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (ticks.valid),
    .tick_ready (ticks.ready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // datapath
  blm_dp #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .ADC_BITS     (ADC_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .adc_reading   (ticks.adc_reading),
    .led_allowed   (ticks.led_allowed),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .cmd           (cmd),
    .stat          (stat),
    .level_valid   (levels.valid),
    .level_ready   (levels.ready),
    .average_level (levels.average_level),
    .level_color   (levels.level_color),
    .color_update  (levels.color_update)
  );

endmodule

// ===== tb/sv/battery_level_monitor_test.sv =====
`timescale 1ns / 100ps

module battery_level_monitor_test;
  import blm_pkg::*;

  localparam int RING_DEPTH    = DEF_WINDOW_DEPTH;
  localparam int SETTLE_CYCLES = 40;
  localparam int DRAIN_LIMIT   = 5000;
  localparam int LONG_HOLD     = 400;
  localparam int CYCLE_LIMIT   = 1500000;
  localparam int RAND_PHASES   = 12;
  localparam int PHASE_TICKS   = 90;
  localparam int QUIET_TICKS   = 20;
  localparam logic [CFG_W-1:0] LIMIT_TOP = 16'd36855;

  typedef struct packed {
    logic [ADC_W-1:0] adc;
    logic             led;
  } tick_word_t;

  typedef struct packed {
    logic [LEVEL_W-1:0] average;
    color_t             color;
    logic               update;
  } level_word_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  blm_tick_if  tick_bus ();
  blm_level_if level_bus ();

  battery_level_monitor u_top (
    .clk       (clk),
    .rst       (rst),
    .ticks     (tick_bus),
    .levels    (level_bus),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // stimulus and expected words
  tick_word_t  tick_queue[$];
  level_word_t pending_levels[$];
  int ticks_queued = 0;
  int ticks_taken = 0;
  int error_count = 0;
  int cycle_count;
  logic tick_fire = 1'b0;

  // predictor copy of the registers and the averaging state
  logic [CFG_W-1:0]   cfg_interval;
  logic [CFG_W-1:0]   cfg_high;
  logic [CFG_W-1:0]   cfg_medium;
  logic [CFG_W-1:0]   cfg_low;
  logic [15:0]        avg_ring [RING_DEPTH];
  logic [19:0]        ring_total;
  logic [3:0]         ring_slot;
  logic [4:0]         ring_fill;
  logic [15:0]        ms_count;

  // sender and receiver pacing
  int burst_left = 0;
  int gap_left = 0;
  int hold_asked = 0;
  int hold_served = 0;
  int hold_left = 0;
  int rx_mode_left = 0;
  int rx_mode = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  // exact test of average against a limit
  function automatic color_t pick_color(input logic [19:0] sum, input logic [4:0] n);
    logic at_high, at_medium, at_low;
    at_high   = 32'(sum) <= 32'(cfg_high) * 32'(n);
    at_medium = 32'(sum) <= 32'(cfg_medium) * 32'(n);
    at_low    = 32'(sum) <= 32'(cfg_low) * 32'(n);
    if (at_high && !at_medium) return COLOR_YELLOW;
    if (at_medium && !at_low) return COLOR_ORANGE;
    if (at_low) return COLOR_RED;
    return COLOR_GREEN;
  endfunction

  // one millisecond tick into the averaging model
  task automatic take_tick(input logic [ADC_W-1:0] adc, input logic led);
    logic [31:0] scaled;
    logic [15:0] sample;
    level_word_t w;
    if (ms_count != 16'hFFFF) ms_count = ms_count + 16'd1;
    if (ms_count >= cfg_interval) begin
      ms_count = 16'd0;
      scaled = 32'(adc) * 32'd9;
      sample = (scaled > 32'hFFFF) ? 16'hFFFF : scaled[15:0];
      ring_total = ring_total - 20'(avg_ring[ring_slot]) + 20'(sample);
      avg_ring[ring_slot] = sample;
      ring_slot = ring_slot + 4'd1;
      if (ring_fill < 5'(RING_DEPTH)) ring_fill = ring_fill + 5'd1;
      w.average = 16'(ring_total / 20'(ring_fill));
      w.color = pick_color(ring_total, ring_fill);
      w.update = led;
      pending_levels.push_back(w);
    end
  endtask

  task automatic queue_tick(input logic [ADC_W-1:0] adc, input logic led);
    tick_word_t t;
    t.adc = adc;
    t.led = led;
    tick_queue.push_back(t);
    ticks_queued++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_write = 1'b0;
    case (idx)
      REG_POLL_INTERVAL: cfg_interval = val;
      REG_HIGH_LIMIT:    cfg_high = val;
      REG_MEDIUM_LIMIT:  cfg_medium = val;
      REG_LOW_LIMIT:     cfg_low = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CFG_W-1:0] interval, input logic [CFG_W-1:0] hi,
                           input logic [CFG_W-1:0] md, input logic [CFG_W-1:0] lo);
    write_reg(REG_POLL_INTERVAL, interval);
    write_reg(REG_HIGH_LIMIT, hi);
    write_reg(REG_MEDIUM_LIMIT, md);
    write_reg(REG_LOW_LIMIT, lo);
  endtask

  // wait for every tick to go in and every word to come out, then let the block settle
  task automatic drain();
    int waited;
    waited = 0;
    while (ticks_taken != ticks_queued) @(negedge clk);
    while (pending_levels.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (pending_levels.size() != 0) begin
      $display("%0t: %0d expected level words never arrived", $time,
               pending_levels.size());
      error_count++;
      pending_levels.delete();
    end
  endtask

  // tick driver, bursts with gaps
  always @(negedge clk) begin
    tick_word_t nxt;
    if (!rst && !(tick_bus.valid && !tick_fire)) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        tick_bus.valid <= 1'b0;
      end else if (tick_queue.size() != 0) begin
        nxt = tick_queue.pop_front();
        tick_bus.adc_reading <= nxt.adc;
        tick_bus.led_allowed <= nxt.led;
        tick_bus.valid <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= ($urandom_range(0, 7) == 0) ? $urandom_range(40, 200)
                                                    : $urandom_range(1, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        tick_bus.valid <= 1'b0;
      end
    end
  end

  // level receiver, own stall pattern plus long hold on request
  always @(negedge clk) begin
    logic take;
    take = 1'b0;
    if (!rst) begin
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (hold_served != hold_asked) begin
        hold_served <= hold_served + 1;
        hold_left <= LONG_HOLD;
      end else begin
        if (rx_mode_left == 0) begin
          rx_mode_left <= $urandom_range(10, 80);
          rx_mode <= $urandom_range(0, 2);
        end else begin
          rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
          0: take = 1'b1;
          1: take = ($urandom_range(0, 3) != 0);
          default: take = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
    level_bus.ready <= take;
  end

  // accepted ticks feed the predictor, accepted words are checked
  always @(posedge clk) begin
    level_word_t want;
    if (rst) begin
      tick_fire <= 1'b0;
    end else begin
      tick_fire <= tick_bus.valid && tick_bus.ready;
      if (tick_bus.valid && tick_bus.ready) begin
        take_tick(tick_bus.adc_reading, tick_bus.led_allowed);
        ticks_taken <= ticks_taken + 1;
      end
      if (level_bus.valid && level_bus.ready) begin
        if (pending_levels.size() == 0) begin
          $display("%0t: unexpected level word, expected none, actual avg %0d colour %0d upd %0d",
                   $time, level_bus.average_level, level_bus.level_color,
                   level_bus.color_update);
          error_count++;
        end else begin
          want = pending_levels.pop_front();
          if (level_bus.average_level !== want.average) begin
            $display("%0t: average_level mismatch, expected %0d actual %0d",
                     $time, want.average, level_bus.average_level);
            error_count++;
          end
          if (level_bus.level_color !== want.color) begin
            $display("%0t: level_color mismatch, expected %0d actual %0d",
                     $time, want.color, level_bus.level_color);
            error_count++;
          end
          if (level_bus.color_update !== want.update) begin
            $display("%0t: color_update mismatch, expected %0d actual %0d",
                     $time, want.update, level_bus.color_update);
            error_count++;
          end
        end
      end
    end
  end

  // overall cycle limit
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("%0t: timeout after %0d cycles", $time, CYCLE_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // main sequence
  initial begin
    int i, p, k;
    logic [CFG_W-1:0] iv, hi, md, lo, tgt;
    logic [ADC_W-1:0] rd;
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = REG_POLL_INTERVAL;
    cfg_data = '0;
    tick_bus.valid = 1'b0;
    tick_bus.adc_reading = '0;
    tick_bus.led_allowed = 1'b0;
    level_bus.ready = 1'b0;
    cfg_interval = RST_POLL_INTERVAL;
    cfg_high = RST_HIGH_LIMIT;
    cfg_medium = RST_MEDIUM_LIMIT;
    cfg_low = RST_LOW_LIMIT;
    for (i = 0; i < RING_DEPTH; i++) avg_ring[i] = '0;
    ring_total = '0;
    ring_slot = '0;
    ring_fill = '0;
    ms_count = '0;
    repeat (12) @(negedge clk);
    rst = 1'b0;

    // directed: poll on every tick, partial window, full window and wrap
    configure(16'd1, RST_HIGH_LIMIT, RST_MEDIUM_LIMIT, RST_LOW_LIMIT);
    queue_tick(12'd0, 1'b0);
    repeat (16) queue_tick(12'hFFF, 1'b1);
    queue_tick(12'd1644, 1'b1);
    queue_tick(12'd1645, 1'b0);
    drain();

    // directed: poll every third tick, limits at the extremes
    configure(16'd3, LIMIT_TOP, 16'd18000, 16'd0);
    for (i = 0; i < 6; i++) queue_tick(12'(2000 + i), i[0]);
    drain();

    // random phases, readings clustered round the thresholds
    for (p = 0; p < RAND_PHASES; p++) begin
      if (p == 2) iv = 16'd1;
      else if ($urandom_range(0, 3) == 0) iv = 16'($urandom_range(5, 40));
      else iv = 16'($urandom_range(1, 4));
      case ($urandom_range(0, 3))
        0: begin
          lo = 16'($urandom_range(0, 30000));
          md = lo + 16'($urandom_range(0, 3000));
          hi = md + 16'($urandom_range(0, 3000));
        end
        1: begin
          lo = 16'(9 * $urandom_range(0, 3400));
          md = lo + 16'(9 * $urandom_range(0, 150));
          hi = md + 16'(9 * $urandom_range(0, 150));
        end
        2: begin
          lo = 16'($urandom_range(0, 36855));
          md = 16'($urandom_range(0, 36855));
          hi = 16'($urandom_range(0, 36855));
        end
        default: begin
          lo = $urandom_range(0, 1) ? LIMIT_TOP : 16'd0;
          md = $urandom_range(0, 1) ? LIMIT_TOP : 16'd0;
          hi = $urandom_range(0, 1) ? LIMIT_TOP : 16'd0;
        end
      endcase
      configure(iv, hi, md, lo);
      // receiver holds off while ticks keep coming, so the block backs up
      if (p == 2) hold_asked++;
      for (i = 0; i < PHASE_TICKS; i++) begin
        case ($urandom_range(0, 2))
          0: tgt = lo / 16'd9;
          1: tgt = md / 16'd9;
          default: tgt = hi / 16'd9;
        endcase
        case ($urandom_range(0, 9))
          0, 1, 2, 3: rd = tgt[ADC_W-1:0];
          4, 5: begin
            k = int'(tgt) + int'($urandom_range(0, 6)) - 3;
            if (k < 0) k = 0;
            if (k > 4095) k = 4095;
            rd = k[ADC_W-1:0];
          end
          6, 7: rd = 12'($urandom_range(0, 4095));
          8: rd = 12'd0;
          default: rd = 12'hFFF;
        endcase
        queue_tick(rd, 1'($urandom_range(0, 1)));
      end
      drain();
    end

    // longest poll interval, a short run of ticks that must not poll
    configure(16'hFFFF, LIMIT_TOP, LIMIT_TOP, LIMIT_TOP);
    for (i = 0; i < QUIET_TICKS; i++) begin
      queue_tick(12'($urandom_range(0, 4095)), 1'($urandom_range(0, 1)));
    end
    drain();

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== battery_level_monitor.f =====
rtl/core/blm_pkg.sv
rtl/core/blm_if.sv
rtl/core/blm_ctrl.sv
rtl/core/blm_dp.sv
rtl/core/battery_level_monitor.sv
tb/sv/battery_level_monitor_test.sv
